>>> hdl/ppt_pkg.sv
package ppt_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PerimW  = 32;
  localparam int unsigned CountW  = 7;

  // magnitude of one coordinate difference and the root it leads to
  localparam int unsigned AbsW   = 16;
  localparam int unsigned RadW   = 50;  // {0, dx^2+dy^2, 16 zero bits}
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned RemW   = RootW + 3;
  localparam int unsigned StepW  = 5;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  localparam logic OpAppend = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StDone     = 2'd0,
    StBadIndex = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } vertex_t;

endpackage

>>> hdl/polygon_perimeter_table.sv
// Ordered table of up to MAX_POINTS vertices in one single-port-read memory.
// An append or a remove word is answered by one result word with the status,
// the perimeter (unsigned, 8 fraction bits, saturating) and the point count.
// A refused word goes straight to its result. An accepted change first, on a
// remove, moves the later points down (one memory read then one write per
// moved point), then, with three or more points, walks all edges through a
// shared datapath: a memory fetch, two 16x16 squarings and a 25-step
// bit-pair square root per edge. Only one word is in work at a time; a new
// word is taken while the last result waits.
module polygon_perimeter_table #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // operation[0], coord_x[16:1], coord_y[32:17], index[38:33], zero pad
  input  logic [ppt_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // status[1:0], perimeter[33:2], point_count[40:34], zero pad
  output logic [ppt_pkg::OutDataW-1:0]    m_axis_tdata_o
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned IW = (CW > ppt_pkg::IndexW) ? CW : ppt_pkg::IndexW;

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_RC_START, S_RC_FIRST, S_FETCH,
    S_DIFF, S_SQ_X, S_SQ_Y, S_SQRT, S_RESULT
  } state_e;

  state_e                         state_q;
  logic [CW-1:0]                  count_q, ptr_q;
  logic [ppt_pkg::PerimW-1:0]     perim_q, sum_q;
  ppt_pkg::status_e               status_q;
  logic                           closing_q;
  ppt_pkg::vertex_t               first_q, prev_q, rdata_q;
  logic [ppt_pkg::AbsW-1:0]       adx_q, ady_q;
  logic [2*ppt_pkg::AbsW-1:0]     sqx_q;
  logic [ppt_pkg::RadW-1:0]       rad_q;
  logic [ppt_pkg::RootW-1:0]      root_q;
  logic [ppt_pkg::RemW-1:0]       rem_q;
  logic [ppt_pkg::StepW-1:0]      step_q;
  logic                           out_valid_q;
  logic [1:0]                     out_status_q;
  logic [ppt_pkg::PerimW-1:0]     out_perim_q;
  logic [ppt_pkg::CountW-1:0]     out_count_q;

  ppt_pkg::vertex_t               mem [MAX_POINTS];

  // input word
  logic                           in_op;
  ppt_pkg::vertex_t               in_vtx;
  logic [ppt_pkg::IndexW-1:0]     in_idx;
  logic                           accept;
  logic [IW-1:0]                  idx_ext, cnt_ext;

  assign in_op    = s_axis_tdata_i[0];
  assign in_vtx.x = s_axis_tdata_i[16:1];
  assign in_vtx.y = s_axis_tdata_i[32:17];
  assign in_idx   = s_axis_tdata_i[38:33];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_ext  = IW'(in_idx);
  assign cnt_ext  = IW'(count_q);

  // memory ports
  logic                           we;
  logic [AW-1:0]                  waddr, raddr;
  ppt_pkg::vertex_t               wdata;

  always_comb begin
    we    = 1'b0;
    waddr = AW'(ptr_q);
    wdata = rdata_q;
    raddr = AW'(ptr_q);
    if (state_q == S_IDLE) begin
      we    = accept && (in_op == ppt_pkg::OpAppend) && (count_q < CW'(MAX_POINTS));
      waddr = AW'(count_q);
      wdata = in_vtx;
    end else if (state_q == S_SHIFT_WR) begin
      we = 1'b1;
    end
    if (state_q == S_SHIFT_RD) begin
      raddr = AW'(ptr_q + CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // edge datapath
  ppt_pkg::vertex_t               cur;
  logic signed [ppt_pkg::CoordW:0] dx, dy;
  logic [ppt_pkg::AbsW-1:0]       adx, ady;
  logic [2*ppt_pkg::AbsW:0]       d2;
  logic [ppt_pkg::RemW-1:0]       rem_sh, trial, rem_n;
  logic [ppt_pkg::RootW-1:0]      root_n;
  logic [ppt_pkg::PerimW:0]       acc;
  logic [ppt_pkg::PerimW-1:0]     sum_n;

  always_comb begin
    cur = closing_q ? first_q : rdata_q;
    dx  = {prev_q.x[ppt_pkg::CoordW-1], prev_q.x} - {cur.x[ppt_pkg::CoordW-1], cur.x};
    dy  = {prev_q.y[ppt_pkg::CoordW-1], prev_q.y} - {cur.y[ppt_pkg::CoordW-1], cur.y};
    adx = dx[ppt_pkg::CoordW] ? ppt_pkg::AbsW'(-dx) : ppt_pkg::AbsW'(dx);
    ady = dy[ppt_pkg::CoordW] ? ppt_pkg::AbsW'(-dy) : ppt_pkg::AbsW'(dy);
    d2  = (2*ppt_pkg::AbsW+1)'(sqx_q) + (2*ppt_pkg::AbsW+1)'(ady_q * ady_q);
    // one result bit per step
    rem_sh = {rem_q[ppt_pkg::RemW-3:0], rad_q[ppt_pkg::RadW-1 -: 2]};
    trial  = ppt_pkg::RemW'({root_q, 2'b01});
    if (rem_sh >= trial) begin
      rem_n  = rem_sh - trial;
      root_n = {root_q[ppt_pkg::RootW-2:0], 1'b1};
    end else begin
      rem_n  = rem_sh;
      root_n = {root_q[ppt_pkg::RootW-2:0], 1'b0};
    end
    acc   = {1'b0, sum_q} + (ppt_pkg::PerimW+1)'(root_n);
    sum_n = acc[ppt_pkg::PerimW] ? '1 : acc[ppt_pkg::PerimW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      ptr_q        <= '0;
      perim_q      <= '0;
      sum_q        <= '0;
      status_q     <= ppt_pkg::StDone;
      closing_q    <= 1'b0;
      first_q      <= '0;
      prev_q       <= '0;
      adx_q        <= '0;
      ady_q        <= '0;
      sqx_q        <= '0;
      rad_q        <= '0;
      root_q       <= '0;
      rem_q        <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_perim_q  <= '0;
      out_count_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && (state_q != S_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ptr_q <= CW'(idx_ext);
            if (in_op == ppt_pkg::OpAppend) begin
              if (count_q >= CW'(MAX_POINTS)) begin
                status_q <= ppt_pkg::StFull;
                state_q  <= S_RESULT;
              end else begin
                status_q <= ppt_pkg::StDone;
                count_q  <= count_q + CW'(1);
                state_q  <= S_RC_START;
              end
            end else if (idx_ext >= cnt_ext) begin
              status_q <= ppt_pkg::StBadIndex;
              state_q  <= S_RESULT;
            end else if (idx_ext + IW'(1) == cnt_ext) begin
              status_q <= ppt_pkg::StDone;
              count_q  <= count_q - CW'(1);
              state_q  <= S_RC_START;
            end else begin
              status_q <= ppt_pkg::StDone;
              state_q  <= S_SHIFT_RD;
            end
          end
        end
        S_SHIFT_RD: state_q <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          ptr_q <= ptr_q + CW'(1);
          if (ptr_q + CW'(2) == count_q) begin
            count_q <= count_q - CW'(1);
            state_q <= S_RC_START;
          end else begin
            state_q <= S_SHIFT_RD;
          end
        end
        S_RC_START: begin
          sum_q     <= '0;
          closing_q <= 1'b0;
          ptr_q     <= '0;
          state_q   <= (count_q < CW'(3)) ? S_RESULT : S_RC_FIRST;
        end
        S_RC_FIRST: state_q <= S_FETCH;  // read of entry 0 in flight
        S_FETCH: begin
          if (ptr_q == '0) begin
            first_q <= rdata_q;
            prev_q  <= rdata_q;
            ptr_q   <= CW'(1);
          end else begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          adx_q   <= adx;
          ady_q   <= ady;
          prev_q  <= cur;
          state_q <= S_SQ_X;
        end
        S_SQ_X: begin
          sqx_q   <= adx_q * adx_q;
          state_q <= S_SQ_Y;
        end
        S_SQ_Y: begin
          rad_q   <= {1'b0, d2, 16'b0};
          rem_q   <= '0;
          root_q  <= '0;
          step_q  <= ppt_pkg::StepW'(ppt_pkg::RootW - 1);
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          rad_q  <= {rad_q[ppt_pkg::RadW-3:0], 2'b00};
          rem_q  <= rem_n;
          root_q <= root_n;
          step_q <= step_q - ppt_pkg::StepW'(1);
          if (step_q == '0) begin
            sum_q <= sum_n;
            if (closing_q) begin
              state_q <= S_RESULT;
            end else if (ptr_q == count_q - CW'(1)) begin
              closing_q <= 1'b1;
              state_q   <= S_DIFF;
            end else begin
              ptr_q   <= ptr_q + CW'(1);
              state_q <= S_FETCH;
            end
          end
        end
        S_RESULT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_count_q  <= ppt_pkg::CountW'(count_q);
            if (status_q == ppt_pkg::StDone) begin
              perim_q     <= sum_q;
              out_perim_q <= sum_q;
            end else begin
              out_perim_q <= perim_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_count_q, out_perim_q, out_status_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("point count above table size");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && status_q == ppt_pkg::StFull) |-> count_q == CW'(MAX_POINTS))
    else $error("full status with room left");

  a_small_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && count_q < CW'(3)) |-> sum_q == '0)
    else $error("nonzero perimeter below three points");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op == ppt_pkg::OpAppend && count_q < CW'(MAX_POINTS))
      |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not add a point");
`endif

endmodule

>>> dv/tb.sv
module tb;

  localparam int unsigned MaxPts = 64;
  localparam int unsigned StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [ppt_pkg::InDataW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [ppt_pkg::OutDataW-1:0] m_axis_tdata_o;

  polygon_perimeter_table #(.MAX_POINTS(MaxPts)) dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [ppt_pkg::CountW-1:0] cnt;
    logic [ppt_pkg::PerimW-1:0] perim;
    ppt_pkg::status_e st;
  } answer_t;

  // shadow copy of the vertex table
  logic signed [ppt_pkg::CoordW-1:0] shx[MaxPts];
  logic signed [ppt_pkg::CoordW-1:0] shy[MaxPts];
  int unsigned sh_cnt;
  logic [ppt_pkg::PerimW-1:0] sh_perim;
  answer_t answers_q[$];

  int errors;
  bit sender_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit sink_hold = 1'b0;
  int quiet_cycles;

  function automatic longint unsigned edge_len256(int unsigned a, int unsigned b);
    longint unsigned dx, dy, v, root, bitv;
    dx = (shx[a] > shx[b]) ? longint'(shx[a]) - shx[b] : longint'(shx[b]) - shx[a];
    dy = (shy[a] > shy[b]) ? longint'(shy[a]) - shy[b] : longint'(shy[b]) - shy[a];
    v = (dx * dx + dy * dy) << 16;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [ppt_pkg::PerimW-1:0] perimeter_of_table();
    longint unsigned sum;
    sum = 0;
    if (sh_cnt < 3) return '0;
    for (int unsigned i = 0; i + 1 < sh_cnt; i++) begin
      sum += edge_len256(i, i + 1);
      if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    end
    sum += edge_len256(0, sh_cnt - 1);
    if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    return sum[ppt_pkg::PerimW-1:0];
  endfunction

  function automatic answer_t apply_word(logic op, logic signed [ppt_pkg::CoordW-1:0] x,
                                         logic signed [ppt_pkg::CoordW-1:0] y,
                                         logic [ppt_pkg::IndexW-1:0] idx);
    answer_t a;
    a.st = ppt_pkg::StDone;
    if (op == ppt_pkg::OpAppend) begin
      if (sh_cnt >= MaxPts) begin
        a.st = ppt_pkg::StFull;
      end else begin
        shx[sh_cnt] = x;
        shy[sh_cnt] = y;
        sh_cnt++;
        sh_perim = perimeter_of_table();
      end
    end else begin
      if (idx >= sh_cnt) begin
        a.st = ppt_pkg::StBadIndex;
      end else begin
        for (int unsigned i = idx; i + 1 < sh_cnt; i++) begin
          shx[i] = shx[i + 1];
          shy[i] = shy[i + 1];
        end
        sh_cnt--;
        sh_perim = perimeter_of_table();
      end
    end
    a.perim = sh_perim;
    a.cnt = sh_cnt[ppt_pkg::CountW-1:0];
    return a;
  endfunction

  task automatic send_word(logic op, logic [ppt_pkg::CoordW-1:0] x,
                           logic [ppt_pkg::CoordW-1:0] y,
                           logic [ppt_pkg::IndexW-1:0] idx);
    int gap;
    // the block leaves idle after it takes each word
    @(negedge clk_i);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i <= {1'b0, idx, y, x, op};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    answers_q.push_back(apply_word(op, x, y, idx));
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic append_pt(logic [ppt_pkg::CoordW-1:0] x, logic [ppt_pkg::CoordW-1:0] y);
    send_word(ppt_pkg::OpAppend, x, y, ppt_pkg::IndexW'($urandom));
  endtask

  task automatic remove_at(logic [ppt_pkg::IndexW-1:0] idx);
    send_word(ppt_pkg::OpRemove, ppt_pkg::CoordW'($urandom), ppt_pkg::CoordW'($urandom), idx);
  endtask

  task automatic drain();
    while (answers_q.size() != 0) @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    answer_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = answer_t'(m_axis_tdata_o[ppt_pkg::CountW+ppt_pkg::PerimW+ppt_pkg::StatusW-1:0]);
      if (answers_q.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, got);
        errors++;
      end else begin
        want = answers_q.pop_front();
        if (got.st !== want.st) begin
          $display("%0t status exp %0d got %0d", $realtime, want.st, got.st);
          errors++;
        end
        if (got.perim !== want.perim) begin
          $display("%0t perimeter exp %h got %h", $realtime, want.perim, got.perim);
          errors++;
        end
        if (got.cnt !== want.cnt) begin
          $display("%0t count exp %0d got %0d", $realtime, want.cnt, got.cnt);
          errors++;
        end
      end
    end
  end

  // receiver ready, in bursts
  always @(negedge clk_i) begin
    int hold;
    if (sink_hold) begin
      m_axis_tready_i <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      hold = $urandom_range(1, 16);
      m_axis_tready_i <= 1'b0;
      repeat (hold) @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else if (!sink_hold) begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  task automatic test_edges();
    remove_at(0);                          // empty table
    append_pt(16'h8000, 16'h8000);
    remove_at(0);                          // last point
    append_pt(16'h8000, 16'h8000);
    append_pt(16'h7FFF, 16'h7FFF);
    append_pt(16'h8000, 16'h7FFF);
    append_pt(16'h7FFF, 16'h8000);
    append_pt(16'h0000, 16'hFFFF);
    remove_at(6'h3F);
    remove_at(5);
    remove_at(1);
    remove_at(3);
    remove_at(0);
    remove_at(0);
    remove_at(0);
    drain();
  endtask

  // fill with far-apart corners: large perimeter, full table, backpressure
  task automatic test_full();
    sender_idle_en = 1'b0;
    sink_hold = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < MaxPts; i++)
        append_pt(i[0] ? 16'h7FFF : 16'h8000, i[1] ? 16'h7FFF : 16'h8000);
    join
    sender_idle_en = 1'b1;
    append_pt(16'h1234, 16'h4321);
    remove_at(6'h3F);
    append_pt(16'h0001, 16'h0002);
    remove_at(0);
    drain();
    while (sh_cnt > 0) remove_at(ppt_pkg::IndexW'($urandom_range(0, sh_cnt - 1)));
    drain();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i == n - 60) begin
        sender_idle_en = 1'b0;
        sink_idle_en = 1'b0;
      end
      r = $urandom_range(0, 9);
      if (r < 6 && sh_cnt < 24) begin
        if ($urandom_range(0, 2) == 0) begin
          append_pt(ppt_pkg::CoordW'($urandom), ppt_pkg::CoordW'($urandom));
        end else begin
          append_pt(ppt_pkg::CoordW'($urandom_range(0, 200) - 100),
                    ppt_pkg::CoordW'($urandom_range(0, 200) - 100));
        end
      end else if (r < 9 && sh_cnt > 0) begin
        remove_at(ppt_pkg::IndexW'($urandom_range(0, sh_cnt - 1)));
      end else begin
        remove_at(ppt_pkg::IndexW'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    errors = 0;
    sh_cnt = 0;
    sh_perim = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_edges();
    test_full();
    test_random(275);
    repeat (4000) begin
      @(negedge clk_i);
    end
    if (errors == 0 && answers_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
